### hdl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore
// Request and outcome codes, FSM state type and default sizes.
// ----------------------------------------------------------------------------
package csem_pkg;

  // Default sizes
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned ThreadIdBits = 8;

  // Fixed field widths of the channels
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned TidW      = 8;
  localparam int unsigned OutcomeW  = 3;
  localparam int unsigned InitCntW  = 16;
  localparam int unsigned CountW    = 32;

  // Request kinds
  typedef enum logic [ReqTypeW-1:0] {
    REQ_WAIT   = 2'd0,
    REQ_SIGNAL = 2'd1,
    REQ_CLOSE  = 2'd2
  } csem_req_e;

  // Result outcomes
  typedef enum logic [OutcomeW-1:0] {
    OUT_WAIT_PASSED = 3'd0,
    OUT_BLOCKED     = 3'd1,
    OUT_RELEASED    = 3'd2,
    OUT_NONE        = 3'd3,
    OUT_OVERFLOW    = 3'd4
  } csem_outcome_e;

  // Control FSM
  typedef enum logic {
    ST_IDLE,
    ST_DELIVER
  } csem_state_e;

endpackage

### hdl/csem_if.sv
// ----------------------------------------------------------------------------
// csem_if: request and result channels of the counting semaphore
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// Request channel
interface csem_req_if;
  logic                          valid;
  logic                          ready;
  logic [csem_pkg::ReqTypeW-1:0] req_type;
  logic [csem_pkg::TidW-1:0]     thread_id;

  modport source (output valid, output req_type, output thread_id, input ready);
  modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

// Result channel
interface csem_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csem_pkg::OutcomeW-1:0] outcome;
  logic [csem_pkg::TidW-1:0]     thread_id_out;
  logic                          last;

  modport source (output valid, output outcome, output thread_id_out, output last,
                  input ready);
  modport sink   (input valid, input outcome, input thread_id_out, input last,
                  output ready);
endinterface

### hdl/counting_semaphore_fifo_waiters_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core: counting semaphore with FIFO waiters
// Signed saturating count plus a circular queue of blocked thread ids held in
// a synchronous memory. Close drains it at one release per unstalled cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  ----------------------------------------
//  req_i     in   valid/ready    req_type[1:0], thread_id[7:0]
//  rsp_o     out  valid/ready    outcome[2:0], thread_id_out[7:0], last
//  cfg       in   cfg_we_i only  cfg_wdata_i[15:0] (initial count)
//
//  A request sits in the input register, then executes once the FSM is
//  idle and the result register is free. Wait, most signals and a close
//  with no waiters finish as they execute. A release first reads the queue
//  memory; a close then gives one release per cycle while results are taken.
//  Result stalls hold the FSM; a new request is taken while a result waits.
//  Reset clears count, pointers and fill; queue contents need no clearing.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_core #(
  parameter int unsigned QueueDepth   = csem_pkg::QueueDepth,
  parameter int unsigned ThreadIdBits = csem_pkg::ThreadIdBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csem_pkg::InitCntW-1:0] cfg_wdata_i,
  csem_req_if.sink                      req_i,
  csem_rsp_if.source                    rsp_o
);

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned CntW  = csem_pkg::CountW;

  localparam logic signed [CntW-1:0] CntMax = {1'b0, {(CntW-1){1'b1}}};
  localparam logic signed [CntW-1:0] CntMin = {1'b1, {(CntW-1){1'b0}}};
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(QueueDepth);
  localparam logic [FillW-1:0] FillOne  = FillW'(1);

  // Input register
  logic                          req_valid_q, req_valid_d;
  logic [csem_pkg::ReqTypeW-1:0] req_type_q;
  logic [csem_pkg::TidW-1:0]     req_tid_q;
  logic                          req_taken;

  // Semaphore state
  logic signed [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0]        head_q, head_d;
  logic [PtrW-1:0]        tail_q, tail_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic                   last_q, last_d;
  csem_pkg::csem_state_e  state_q, state_d;

  // Queue memory
  logic [ThreadIdBits-1:0] mem_q [QueueDepth];
  logic [ThreadIdBits-1:0] rd_data_q;
  logic                    mem_we;
  logic                    mem_re;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [csem_pkg::OutcomeW-1:0] out_outcome_q;
  logic [csem_pkg::TidW-1:0]     out_tid_q;
  logic                          out_last_q;
  logic                          out_load;
  csem_pkg::csem_outcome_e       out_outcome;
  logic [csem_pkg::TidW-1:0]     out_tid;
  logic                          out_last;

  // Shared decode
  logic                   slot_free;
  logic                   exec;
  logic signed [CntW-1:0] count_inc;
  logic signed [CntW-1:0] count_dec;
  logic                   sig_pop;
  logic                   close_pop;
  logic [PtrW-1:0]        head_nxt;
  logic [PtrW-1:0]        tail_nxt;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign exec      = (state_q == csem_pkg::ST_IDLE) && req_valid_q && slot_free;
  assign count_inc = (count_q == CntMax) ? count_q : count_q + 1;
  assign count_dec = (count_q == CntMin) ? count_q : count_q - 1;
  assign sig_pop   = (req_type_q == csem_pkg::REQ_SIGNAL) && (count_inc <= 0)
                     && (fill_q != '0);
  assign close_pop = (req_type_q == csem_pkg::REQ_CLOSE) && (fill_q != '0);
  assign head_nxt  = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_nxt  = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      csem_pkg::ST_IDLE: begin
        if (!cfg_we_i && exec && (sig_pop || close_pop)) begin
          state_d = csem_pkg::ST_DELIVER;
        end
      end
      csem_pkg::ST_DELIVER: begin
        if (slot_free && last_q) begin
          state_d = csem_pkg::ST_IDLE;
        end
      end
      default: state_d = csem_pkg::ST_IDLE;
    endcase
  end

  // Datapath and results
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    req_taken   = 1'b0;
    out_load    = 1'b0;
    out_outcome = csem_pkg::OUT_NONE;
    out_tid     = '0;
    out_last    = 1'b1;

    if (cfg_we_i) begin
      // creation: load count, empty queue
      count_d = CntW'(cfg_wdata_i);
      head_d  = '0;
      tail_d  = '0;
      fill_d  = '0;
    end else begin
      case (state_q)
        csem_pkg::ST_IDLE: begin
          if (exec) begin
            req_taken = 1'b1;
            case (req_type_q)
              csem_pkg::REQ_WAIT: begin
                out_load = 1'b1;
                if (count_q > 0) begin
                  count_d     = count_q - 1;
                  out_outcome = csem_pkg::OUT_WAIT_PASSED;
                end else if (fill_q == FillFull) begin
                  out_outcome = csem_pkg::OUT_OVERFLOW;
                end else begin
                  count_d     = count_dec;
                  mem_we      = 1'b1;
                  tail_d      = tail_nxt;
                  fill_d      = fill_q + 1'b1;
                  out_outcome = csem_pkg::OUT_BLOCKED;
                  out_tid     = csem_pkg::TidW'(ThreadIdBits'(req_tid_q));
                end
              end
              csem_pkg::REQ_SIGNAL: begin
                count_d = count_inc;
                if (sig_pop) begin
                  mem_re = 1'b1;
                  head_d = head_nxt;
                  fill_d = fill_q - 1'b1;
                  last_d = 1'b1;
                end else begin
                  out_load = 1'b1;
                end
              end
              csem_pkg::REQ_CLOSE: begin
                if (close_pop) begin
                  mem_re = 1'b1;
                  head_d = head_nxt;
                  fill_d = fill_q - 1'b1;
                  last_d = (fill_q == FillOne);
                end else begin
                  out_load = 1'b1;
                end
              end
              default: begin
                out_load = 1'b1;
              end
            endcase
          end
        end
        csem_pkg::ST_DELIVER: begin
          // present read data; issue the next read of a drain meanwhile
          if (slot_free) begin
            out_load    = 1'b1;
            out_outcome = csem_pkg::OUT_RELEASED;
            out_tid     = csem_pkg::TidW'(rd_data_q);
            out_last    = last_q;
            if (!last_q) begin
              mem_re = 1'b1;
              head_d = head_nxt;
              fill_d = fill_q - 1'b1;
              last_d = (fill_q == FillOne);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Input register control
  assign req_i.ready = !req_valid_q;

  always_comb begin
    req_valid_d = req_valid_q;
    if (req_i.valid && req_i.ready) begin
      req_valid_d = 1'b1;
    end else if (req_taken) begin
      req_valid_d = 1'b0;
    end
  end

  // Result register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      last_q      <= 1'b0;
      state_q     <= csem_pkg::ST_IDLE;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      last_q      <= last_d;
      state_q     <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= req_i.req_type;
      req_tid_q  <= req_i.thread_id;
    end
    if (out_load) begin
      out_outcome_q <= out_outcome;
      out_tid_q     <= out_tid;
      out_last_q    <= out_last;
    end
  end

  // Waiter queue memory: write at tail, registered read at head.
  // A write lands before any later read of the same slot can be issued.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= ThreadIdBits'(req_tid_q);
    end
    if (mem_re) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  // Result channel
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.outcome       = out_outcome_q;
  assign rsp_o.thread_id_out = out_tid_q;
  assign rsp_o.last          = out_last_q;

endmodule
